/* sv/wkn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkn_pkg
// Shared widths, constants, control types and tables for the week number
// pipeline.
// ----------------------------------------------------------------------------
package wkn_pkg;

  localparam int DAY_W   = 6;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int WEEK_W  = 6;
  localparam int DELTA_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // internal widths
  localparam int A_W   = 16;  // floor(t/12), signed
  localparam int R_W   = 4;   // t mod 12
  localparam int FR_W  = 9;   // month prefix days
  localparam int QP_W  = 15;  // non-negative century quotient input
  localparam int Q100_W = 9;
  localparam int JDN_W = 23;  // day count, always positive
  localparam int JQ_W  = 21;  // day count / 7
  localparam int ALN_W = 24;
  localparam int DIFF_W = 25;
  localparam int SEL_W = 11;
  localparam int RAW_W = 9;
  localparam int SUM_W = 11;
  localparam int Q54_W = 5;

  localparam logic [JDN_W-1:0] JDN_BASE = JDN_W'(1721119);
  localparam int MUL_YEAR = 367;

  // reciprocal multipliers: x/c == (x * RECIP) >> SHIFT over the used range
  localparam logic [QP_W-1:0]  RECIP100   = QP_W'(20972);
  localparam int               SH100      = 21;
  localparam logic [23:0]      RECIP7_J   = 24'd9586981;
  localparam int               SH7_J      = 26;
  localparam logic [11:0]      RECIP7_W   = 12'd2341;
  localparam int               SH7_W      = 14;
  localparam logic [9:0]       RECIP54    = 10'd607;
  localparam int               SH54       = 15;

  localparam logic [3:0] OFS_ISO      = 4'd10;
  localparam logic [3:0] OFS_JAN1     = 4'd12;
  localparam logic [3:0] OFS_JAN1_MON = 4'd13;

  localparam int WEEK_MOD = 54;
  localparam int WEEK_MAX = 53;
  localparam int DAYS_WK  = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEEK1_HAS_JAN1    = 2'd0,
    CFG_START_FROM_MONDAY = 2'd1,
    CFG_WEEK_DELTA        = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic s1;
    logic s2;
  } stg_en_t;

  // floor((734*r + 15) / 24) for r = 0..11
  function automatic logic [FR_W-1:0] cum_days(input logic [R_W-1:0] r);
    logic [FR_W-1:0] v;
    case (r)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/wkn_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkn_in_if
// Date request channel: valid/ready with day, month and year.
// ----------------------------------------------------------------------------
interface wkn_in_if;
  logic                       valid;
  logic                       ready;
  logic [wkn_pkg::DAY_W-1:0]   day_of_month;
  logic [wkn_pkg::MONTH_W-1:0] month_num;
  logic [wkn_pkg::YEAR_W-1:0]  year_num;

  modport source (output valid, day_of_month, month_num, year_num, input ready);
  modport sink   (input valid, day_of_month, month_num, year_num, output ready);
endinterface

/* sv/wkn_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkn_out_if
// Week number result channel: valid/ready with adjusted and raw week.
// ----------------------------------------------------------------------------
interface wkn_out_if;
  logic                      valid;
  logic                      ready;
  logic [wkn_pkg::WEEK_W-1:0] week_number;
  logic [wkn_pkg::WEEK_W-1:0] raw_week;

  modport source (output valid, week_number, raw_week, input ready);
  modport sink   (input valid, week_number, raw_week, output ready);
endinterface

/* sv/week_number_from_date_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// week_number_from_date_top
// Week number of a Gregorian date, ISO 8601 or week-one-holds-January-first,
// with a signed week adjustment wrapped into 0..53.
// ----------------------------------------------------------------------------
// A date request goes through a seven-stage pipeline to the output channel.
// One request per cycle is sustained while the output accepts results; every
// stage has its own valid bit and holds under backpressure, so empty stages
// close up behind a stalled output. The stage depth is set by the day count
// (two stages), the divide-by-seven multiplies and the modulo-54 wrap.
// Configuration is sampled by in-flight requests, so write it only while the
// pipeline is empty.
module week_number_from_date_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  wkn_in_if.sink                           req_i,
  wkn_out_if.source                        rsp_o,
  input  logic                             cfg_we_i,
  input  logic [wkn_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wkn_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int NSTG = 7;
  localparam int NDC  = 4;  // main date and three January firsts
  localparam int JP_W = wkn_pkg::JDN_W + 24;
  localparam int WP_W = wkn_pkg::SEL_W + 12;
  localparam int MP_W = 20;

  // configuration
  logic                               week1_q;
  logic                               monday_q;
  logic signed [wkn_pkg::DELTA_W-1:0] delta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      week1_q  <= 1'b0;
      monday_q <= 1'b0;
      delta_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wkn_pkg::CFG_WEEK1_HAS_JAN1:    week1_q  <= cfg_wdata_i[0];
        wkn_pkg::CFG_START_FROM_MONDAY: monday_q <= cfg_wdata_i[0];
        wkn_pkg::CFG_WEEK_DELTA:        delta_q  <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTG:1] v_q;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !v_q[NSTG] || rsp_o.ready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= req_i.valid;
      for (int i = 2; i <= NSTG; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  assign req_i.ready = en[1];

  // stages 1-2: day counts
  logic signed [wkn_pkg::A_W-1:0] yr;
  logic signed [wkn_pkg::A_W-1:0] a_in [NDC];
  logic [wkn_pkg::R_W-1:0]        r_in [NDC];
  logic [wkn_pkg::DAY_W-1:0]      d_in [NDC];
  logic [wkn_pkg::JDN_W-1:0]      jdn  [NDC];
  wkn_pkg::stg_en_t               dc_en;

  always_comb begin
    yr = $signed(wkn_pkg::A_W'(req_i.year_num));
    if (req_i.month_num < 4'd3) begin
      a_in[0] = yr - 16'sd1;
      r_in[0] = req_i.month_num + 4'd9;
    end else if (req_i.month_num == 4'd15) begin
      a_in[0] = yr + 16'sd1;
      r_in[0] = '0;
    end else begin
      a_in[0] = yr;
      r_in[0] = req_i.month_num - 4'd3;
    end
    d_in[0] = req_i.day_of_month;
    // January first of year+1, year, year-1
    for (int k = 1; k < NDC; k++) begin
      a_in[k] = yr - wkn_pkg::A_W'(k - 1);
      r_in[k] = 4'd10;
      d_in[k] = 6'd1;
    end
    dc_en.s1 = en[1];
    dc_en.s2 = en[2];
  end

  for (genvar g = 0; g < NDC; g++) begin : g_dc
    wkn_day_count u_dc (
      .clk_i (clk_i),
      .en_i  (dc_en),
      .a_i   (a_in[g]),
      .r_i   (r_in[g]),
      .d_i   (d_in[g]),
      .jdn_o (jdn[g])
    );
  end

  // stage 3: day count / 7
  logic [JP_W-1:0]               jp;
  logic [wkn_pkg::JQ_W-1:0]      jq_q;
  logic [wkn_pkg::JDN_W-1:0]     j1_q [NDC-1];

  assign jp = JP_W'(jdn[0]) * JP_W'(wkn_pkg::RECIP7_J);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      jq_q <= jp[wkn_pkg::SH7_J +: wkn_pkg::JQ_W];
      for (int k = 0; k < NDC - 1; k++) begin
        j1_q[k] <= jdn[k+1];
      end
    end
  end

  // stage 4: align and pick the first candidate year with a positive week
  logic [3:0]                         ofs;
  logic [wkn_pkg::ALN_W-1:0]          aligned;
  logic signed [wkn_pkg::DIFF_W-1:0]  diff [NDC-1];
  logic [NDC-2:0]                     pos;
  logic [wkn_pkg::SEL_W-1:0]          sel_d;
  logic                               none_d;
  logic [wkn_pkg::SEL_W-1:0]          sel_q;
  logic                               none_q;

  always_comb begin
    if (week1_q) begin
      ofs = monday_q ? wkn_pkg::OFS_JAN1_MON : wkn_pkg::OFS_JAN1;
    end else begin
      ofs = wkn_pkg::OFS_ISO;
    end
    aligned = (wkn_pkg::ALN_W'(jq_q) << 3) - wkn_pkg::ALN_W'(jq_q)
            + wkn_pkg::ALN_W'(ofs);
    for (int k = 0; k < NDC - 1; k++) begin
      diff[k] = $signed(wkn_pkg::DIFF_W'(aligned)) - $signed(wkn_pkg::DIFF_W'(j1_q[k]));
      pos[k]  = !diff[k][wkn_pkg::DIFF_W-1] &&
                (diff[k] >= $signed(wkn_pkg::DIFF_W'(wkn_pkg::DAYS_WK)));
    end
    none_d = 1'b0;
    if (pos[0]) begin
      sel_d = diff[0][wkn_pkg::SEL_W-1:0];
    end else if (pos[1]) begin
      sel_d = diff[1][wkn_pkg::SEL_W-1:0];
    end else if (pos[2]) begin
      sel_d = diff[2][wkn_pkg::SEL_W-1:0];
    end else begin
      sel_d  = '0;
      none_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      sel_q  <= sel_d;
      none_q <= none_d;
    end
  end

  // stage 5: raw week = diff / 7
  logic [WP_W-1:0]           wp;
  logic [wkn_pkg::RAW_W-1:0] raw5_q;

  assign wp = WP_W'(sel_q) * WP_W'(wkn_pkg::RECIP7_W);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      raw5_q <= none_q ? wkn_pkg::RAW_W'(1) : wp[wkn_pkg::SH7_W +: wkn_pkg::RAW_W];
    end
  end

  // stage 6: add delta, quotient by 54
  logic signed [wkn_pkg::SUM_W-1:0] s_d;
  logic [MP_W-1:0]                  mp;
  logic signed [wkn_pkg::SUM_W-1:0] s_q;
  logic [wkn_pkg::Q54_W-1:0]        q54_q;
  logic [wkn_pkg::RAW_W-1:0]        raw6_q;

  always_comb begin
    s_d = $signed(wkn_pkg::SUM_W'(raw5_q)) + wkn_pkg::SUM_W'(delta_q);
    mp  = MP_W'(s_d[9:0]) * MP_W'(wkn_pkg::RECIP54);
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s_q    <= s_d;
      q54_q  <= mp[wkn_pkg::SH54 +: wkn_pkg::Q54_W];
      raw6_q <= raw5_q;
    end
  end

  // stage 7: truncating remainder and wrap
  logic [9:0]                    rem;
  logic [wkn_pkg::SUM_W-1:0]     ns_full;
  logic [6:0]                    ns;
  logic [6:0]                    rn;
  logic [wkn_pkg::WEEK_W-1:0]    wk_d;
  logic [wkn_pkg::WEEK_W-1:0]    wk_q;
  logic [wkn_pkg::WEEK_W-1:0]    raw7_q;

  always_comb begin
    rem     = s_q[9:0] - 10'(q54_q) * 10'(wkn_pkg::WEEK_MOD);
    ns_full = -s_q;
    ns      = ns_full[6:0];
    rn      = (ns >= 7'(wkn_pkg::WEEK_MOD)) ? ns - 7'(wkn_pkg::WEEK_MOD) : ns;
    if (s_q[wkn_pkg::SUM_W-1]) begin
      wk_d = wkn_pkg::WEEK_W'(7'(wkn_pkg::WEEK_MAX) - rn);
    end else if (rem[5:0] == '0) begin
      wk_d = wkn_pkg::WEEK_W'(wkn_pkg::WEEK_MAX);
    end else begin
      wk_d = rem[wkn_pkg::WEEK_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      wk_q   <= wk_d;
      raw7_q <= raw6_q[wkn_pkg::WEEK_W-1:0];
    end
  end

  assign rsp_o.valid       = v_q[NSTG];
  assign rsp_o.week_number = wk_q;
  assign rsp_o.raw_week    = raw7_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> v_q[1])
    else $error("accepted request did not enter stage 1");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NSTG] |-> req_i.ready)
    else $error("input stalled with empty output stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.raw_week != '0 &&
                     rsp_o.raw_week <= wkn_pkg::WEEK_W'(wkn_pkg::WEEK_MAX)))
    else $error("raw week out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.week_number <= wkn_pkg::WEEK_W'(wkn_pkg::WEEK_MAX))
    else $error("week number above 53");

endmodule

/* sv/wkn_day_count.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkn_day_count
// Two-stage day count: from a = floor(t/12), r = t mod 12 and the day,
// forms the Julian-style day number with truncating division semantics.
// ----------------------------------------------------------------------------
module wkn_day_count (
  input  logic                              clk_i,
  input  wkn_pkg::stg_en_t                  en_i,
  input  logic signed [wkn_pkg::A_W-1:0]    a_i,
  input  logic [wkn_pkg::R_W-1:0]           r_i,
  input  logic [wkn_pkg::DAY_W-1:0]         d_i,
  output logic [wkn_pkg::JDN_W-1:0]         jdn_o
);

  localparam int PW = 2 * wkn_pkg::QP_W;

  logic signed [wkn_pkg::A_W-1:0] q_d;
  logic [wkn_pkg::QP_W-1:0]       qp_d;
  logic [PW-1:0]                  p100_d;

  logic signed [wkn_pkg::A_W-1:0] a_q;
  logic signed [wkn_pkg::A_W-1:0] q_q;
  logic                           neg_q;
  logic [wkn_pkg::FR_W-1:0]       fr_q;
  logic [wkn_pkg::QP_W-1:0]       qp_q;
  logic [wkn_pkg::Q100_W-1:0]     q100_q;
  logic [wkn_pkg::DAY_W-1:0]      d_q;

  logic signed [wkn_pkg::DIFF_W-1:0] j_d;
  logic [wkn_pkg::Q100_W-1:0]        q400;
  logic [wkn_pkg::QP_W-1:0]          q4;
  logic [wkn_pkg::JDN_W-1:0]         jdn_q;

  // t < 0 only when a < 0; trunc(t/12) is then a + 1
  always_comb begin
    q_d    = a_i[wkn_pkg::A_W-1] ? a_i + 16'sd1 : a_i;
    qp_d   = a_i[wkn_pkg::A_W-1] ? '0 : q_d[wkn_pkg::QP_W-1:0];
    p100_d = PW'(qp_d) * PW'(wkn_pkg::RECIP100);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      a_q    <= a_i;
      q_q    <= q_d;
      neg_q  <= a_i[wkn_pkg::A_W-1];
      fr_q   <= wkn_pkg::cum_days(r_i);
      qp_q   <= qp_d;
      q100_q <= p100_d[wkn_pkg::SH100 +: wkn_pkg::Q100_W];
      d_q    <= d_i;
    end
  end

  // negative numerator is never a multiple of 24, so trunc = floor + 1
  always_comb begin
    q400 = q100_q >> 2;
    q4   = qp_q >> 2;
    j_d  = wkn_pkg::DIFF_W'(a_q) * wkn_pkg::DIFF_W'(wkn_pkg::MUL_YEAR)
         + $signed(wkn_pkg::DIFF_W'(fr_q))
         + $signed(wkn_pkg::DIFF_W'(neg_q))
         - (wkn_pkg::DIFF_W'(q_q) <<< 1)
         + $signed(wkn_pkg::DIFF_W'(q4))
         - $signed(wkn_pkg::DIFF_W'(q100_q))
         + $signed(wkn_pkg::DIFF_W'(q400))
         + $signed(wkn_pkg::DIFF_W'(d_q))
         + $signed(wkn_pkg::DIFF_W'(wkn_pkg::JDN_BASE));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      jdn_q <= j_d[wkn_pkg::JDN_W-1:0];
    end
  end

  assign jdn_o = jdn_q;

endmodule

/* test/tb_week_number_from_date_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_week_number_from_date_top
// Self-checking bench for the week number pipeline.
// ----------------------------------------------------------------------------
// Date requests go in on the request channel. Each accepted request gets its
// expected adjusted and raw week from an in-bench calendar predictor. The
// results are checked in order against the response channel. Directed dates
// cover the year edges, out-of-range days and months, year zero and the top
// year. They also cover both week modes and delta wrap at the extremes, plus
// a write to an unused register index. Random phases follow, each under its
// own register setting, with random stalls on both channels in all but one.
// ----------------------------------------------------------------------------
module tb_week_number_from_date_top;

  localparam int PIPE_LAT = 7;
  localparam logic [wkn_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic [wkn_pkg::WEEK_W-1:0] week_number;
    logic [wkn_pkg::WEEK_W-1:0] raw_week;
  } week_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [wkn_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [wkn_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  wkn_in_if  req_if ();
  wkn_out_if rsp_if ();

  week_number_from_date_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // predictor copy of the registers
  logic                               mdl_week1_has_jan1;
  logic                               mdl_start_from_monday;
  logic signed [wkn_pkg::DELTA_W-1:0] mdl_week_delta;

  week_result_t pending_weeks[$];
  bit gaps_on;
  int n_requests;
  int n_checked;
  int n_cfg_writes;
  int n_mismatches;

  function automatic longint day_serial(longint d, longint m, longint y);
    longint t;
    longint q;
    t = 12 * y + m - 3;
    q = t / 12;
    return (734 * t + 15) / 24 - 2 * q + q / 4 - q / 100 + q / 400 + d + 1721119;
  endfunction

  function automatic week_result_t predict_week(input logic [wkn_pkg::DAY_W-1:0] d,
                                                input logic [wkn_pkg::MONTH_W-1:0] m,
                                                input logic [wkn_pkg::YEAR_W-1:0] y);
    longint ofs;
    longint yr;
    longint aligned;
    longint w;
    longint raw;
    longint wk;
    week_result_t r;
    yr = longint'(y);
    if (mdl_week1_has_jan1) begin
      ofs = mdl_start_from_monday ? 13 : 12;
    end else begin
      ofs = 10;
    end
    aligned = 7 * (day_serial(longint'(d), longint'(m), yr) / 7) + ofs;
    raw = 1;
    for (int k = 1; k >= -1; k--) begin
      w = (aligned - day_serial(1, 1, yr + k)) / 7;
      if (w > 0) begin
        raw = w;
        break;
      end
    end
    wk = (raw + longint'(mdl_week_delta)) % 54;
    if (wk <= 0) begin
      wk += 53;
    end
    r.week_number = wk[wkn_pkg::WEEK_W-1:0];
    r.raw_week    = raw[wkn_pkg::WEEK_W-1:0];
    return r;
  endfunction

  function automatic void note_mismatch(string what, int want, int got);
    n_mismatches++;
    if (n_mismatches <= 10) begin
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // response check
  always @(posedge clk_i) begin : check_results
    week_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_weeks.size() == 0) begin
        note_mismatch("unrequested result, week", -1, rsp_if.week_number);
      end else begin
        want = pending_weeks.pop_front();
        n_checked++;
        if (rsp_if.week_number !== want.week_number) begin
          note_mismatch("week_number", want.week_number, rsp_if.week_number);
        end
        if (rsp_if.raw_week !== want.raw_week) begin
          note_mismatch("raw_week", want.raw_week, rsp_if.raw_week);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= !(gaps_on && ($urandom_range(99) < 6));
  end

  task automatic write_reg(input logic [wkn_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[wkn_pkg::CFG_DATA_W-1:0];
    case (idx)
      wkn_pkg::CFG_WEEK1_HAS_JAN1:    mdl_week1_has_jan1    = value[0];
      wkn_pkg::CFG_START_FROM_MONDAY: mdl_start_from_monday = value[0];
      wkn_pkg::CFG_WEEK_DELTA:        mdl_week_delta        = value[wkn_pkg::DELTA_W-1:0];
      default: ;
    endcase
    n_cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input bit jan1, input bit monday, input int delta);
    write_reg(wkn_pkg::CFG_WEEK1_HAS_JAN1, jan1);
    write_reg(wkn_pkg::CFG_START_FROM_MONDAY, monday);
    write_reg(wkn_pkg::CFG_WEEK_DELTA, delta);
  endtask

  task automatic send_date(input logic [wkn_pkg::DAY_W-1:0] d,
                           input logic [wkn_pkg::MONTH_W-1:0] m,
                           input logic [wkn_pkg::YEAR_W-1:0] y);
    while (gaps_on && ($urandom_range(99) < 6)) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.day_of_month <= d;
    req_if.month_num    <= m;
    req_if.year_num     <= y;
    do @(posedge clk_i); while (!req_if.ready);
    pending_weeks.push_back(predict_week(d, m, y));
    n_requests++;
  endtask

  // hold off until the pipeline is empty
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_weeks.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  task automatic test_iso_dates();
    set_config(1'b0, 1'b0, 0);
    send_date(6'd1, 4'd1, 14'd2021);
    send_date(6'd31, 4'd12, 14'd2020);
    send_date(6'd30, 4'd12, 14'd2024);
    send_date(6'd4, 4'd1, 14'd2021);
    send_date(6'd1, 4'd1, 14'd1);
    send_date(6'd31, 4'd12, 14'd9999);
    send_date(6'd0, 4'd3, 14'd2000);
    send_date(6'd63, 4'd2, 14'd2023);
    send_date(6'd15, 4'd0, 14'd2022);
    send_date(6'd20, 4'd15, 14'd2022);
    send_date(6'd0, 4'd0, 14'd0);
    send_date(6'd63, 4'd15, 14'd16383);
    drain();
  endtask

  task automatic test_jan1_modes();
    set_config(1'b1, 1'b0, 0);
    send_date(6'd1, 4'd1, 14'd2022);
    send_date(6'd31, 4'd12, 14'd2021);
    send_date(6'd3, 4'd1, 14'd2023);
    drain();
    set_config(1'b1, 1'b1, 0);
    send_date(6'd1, 4'd1, 14'd2022);
    send_date(6'd31, 4'd12, 14'd2021);
    send_date(6'd3, 4'd1, 14'd2023);
    drain();
  endtask

  task automatic test_delta_wrap();
    int deltas[6] = '{-53, 53, -54, 54, -64, 63};
    foreach (deltas[i]) begin
      set_config(i[0], i[1], deltas[i]);
      send_date(6'd4, 4'd1, 14'd2021);
      send_date(6'd31, 4'd12, 14'd2020);
      drain();
    end
  endtask

  task automatic test_unused_index();
    set_config(1'b0, 1'b0, 5);
    write_reg(CFG_IDX_UNUSED, 7'h7f);
    send_date(6'd28, 4'd12, 14'd2026);
    send_date(6'd2, 4'd1, 14'd2027);
    drain();
  endtask

  function automatic void random_date(output logic [wkn_pkg::DAY_W-1:0] d,
                                      output logic [wkn_pkg::MONTH_W-1:0] m,
                                      output logic [wkn_pkg::YEAR_W-1:0] y);
    int pick;
    pick = $urandom_range(9);
    if (pick <= 3) begin
      // around new year, where week 52/53/1 is decided
      if ($urandom_range(1)) begin
        m = 4'd12;
        d = wkn_pkg::DAY_W'($urandom_range(31, 20));
      end else begin
        m = 4'd1;
        d = wkn_pkg::DAY_W'($urandom_range(10, 1));
      end
      y = wkn_pkg::YEAR_W'($urandom_range(9999, 1));
    end else if (pick <= 6) begin
      m = wkn_pkg::MONTH_W'($urandom_range(12, 1));
      d = wkn_pkg::DAY_W'($urandom_range(31, 1));
      y = wkn_pkg::YEAR_W'($urandom_range(9999, 1));
    end else if (pick == 8) begin
      d = wkn_pkg::DAY_W'($urandom_range(63));
      m = wkn_pkg::MONTH_W'($urandom_range(15));
      case ($urandom_range(3))
        0:       y = '0;
        1:       y = wkn_pkg::YEAR_W'(1);
        2:       y = wkn_pkg::YEAR_W'(9999);
        default: y = '1;
      endcase
    end else begin
      d = wkn_pkg::DAY_W'($urandom());
      m = wkn_pkg::MONTH_W'($urandom());
      y = wkn_pkg::YEAR_W'($urandom());
    end
  endfunction

  task automatic run_random_phase(input int count, input bit jan1, input bit monday,
                                  input int delta, input bit with_gaps);
    logic [wkn_pkg::DAY_W-1:0]   d;
    logic [wkn_pkg::MONTH_W-1:0] m;
    logic [wkn_pkg::YEAR_W-1:0]  y;
    set_config(jan1, monday, delta);
    gaps_on = with_gaps;
    for (int i = 0; i < count; i++) begin
      random_date(d, m, y);
      send_date(d, m, y);
      if (i == count / 2 && $urandom_range(1)) begin
        drain();
      end
    end
    drain();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_dates();
    run_random_phase(65, 1'b0, 1'b0, 0, 1'b1);
    run_random_phase(65, 1'b1, 1'b0, 0, 1'b1);
    run_random_phase(65, 1'b1, 1'b1, 0, 1'b0);
    run_random_phase(65, 1'b0, 1'b0, -53, 1'b1);
    run_random_phase(65, 1'b1, 1'b1, 53, 1'b1);
    run_random_phase(65, $urandom_range(1), $urandom_range(1),
                     $urandom_range(63) - 64 + $urandom_range(64), 1'b1);
  endtask

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= wkn_pkg::CFG_WEEK1_HAS_JAN1;
    cfg_wdata_i         <= '0;
    req_if.valid        <= 1'b0;
    req_if.day_of_month <= '0;
    req_if.month_num    <= '0;
    req_if.year_num     <= '0;
    mdl_week1_has_jan1    = 1'b0;
    mdl_start_from_monday = 1'b0;
    mdl_week_delta        = '0;
    gaps_on      = 1'b1;
    n_requests   = 0;
    n_checked    = 0;
    n_cfg_writes = 0;
    n_mismatches = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_iso_dates();
    test_jan1_modes();
    test_delta_wrap();
    test_unused_index();
    test_random_dates();

    drain();
    $display("Run covered %0d date requests (%0d results checked), %0d register writes,",
             n_requests, n_checked, n_cfg_writes);
    $display("ISO and January-first week modes, deltas across -64..63, year 0..16383.");
    if (n_mismatches == 0 && pending_weeks.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Timeout with %0d results still expected", pending_weeks.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
